FILE: hw/rtl/esrv_pkg.sv
// ----------------------------------------------------------------------------
// esrv_pkg
// Types and constants shared by the engine start ramp validator modules.
// ----------------------------------------------------------------------------
package esrv_pkg;

  // ramp machine phases
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_CHECK = 2'd1,
    PH_DONE  = 2'd2,
    PH_RESET = 2'd3
  } phase_t;

  // configuration register indexes
  localparam logic [2:0] REG_CHECK_ENABLE     = 3'd0;
  localparam logic [2:0] REG_CRANK_DISCONNECT = 3'd1;
  localparam logic [2:0] REG_UNDERSPEED_LIMIT = 3'd2;
  localparam logic [2:0] REG_UNDERSPEED_EN    = 3'd3;
  localparam logic [2:0] REG_RAMP_TIMEOUT     = 3'd4;

  localparam int ELAPSED_W = 17;
  localparam int SAMPLE_W  = 16;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

  // speed threshold floor and default
  localparam logic [15:0] LOWER_SPEED_FLOOR   = 16'd300;
  localparam logic [15:0] UPPER_SPEED_DEFAULT = 16'd1200;

  // minimum ramp times in ms
  localparam logic [ELAPSED_W-1:0] MIN_SPEED_RAMP_MS = 17'd500;
  localparam logic [ELAPSED_W-1:0] MIN_VOLT_RAMP_MS  = 17'd500;

  // fixed voltage thresholds
  localparam logic [SAMPLE_W-1:0] VOLT_LOW_LEVEL  = 16'd40;
  localparam logic [SAMPLE_W-1:0] VOLT_HIGH_LEVEL = 16'd180;

  localparam logic [15:0] MS_PER_S         = 16'd1000;
  localparam logic [15:0] TIMEOUT_MS_RESET = 16'd10000;

  // derived configuration seen by the ramp machines
  typedef struct packed {
    logic                check_enable;
    logic [SAMPLE_W-1:0] speed_lo;
    logic [SAMPLE_W-1:0] speed_hi;
    logic [15:0]         timeout_ms;
  } cfg_t;

endpackage

FILE: hw/rtl/esrv_cfg_regs.sv
// ----------------------------------------------------------------------------
// esrv_cfg_regs
// Configuration registers and derived speed thresholds and timeout in ms.
// ----------------------------------------------------------------------------
module esrv_cfg_regs
  import esrv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output cfg_t        cfg
);

  logic        check_enable;
  logic [15:0] crank_disconnect_rpm;
  logic [15:0] underspeed_limit_rpm;
  logic        underspeed_enable;
  logic [15:0] timeout_ms;

  // register writes, timeout kept in ms
  always_ff @(posedge clk) begin
    if (rst) begin
      check_enable         <= 1'b0;
      crank_disconnect_rpm <= '0;
      underspeed_limit_rpm <= '0;
      underspeed_enable    <= 1'b0;
      timeout_ms           <= TIMEOUT_MS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHECK_ENABLE:     check_enable         <= cfg_wdata[0];
        REG_CRANK_DISCONNECT: crank_disconnect_rpm <= cfg_wdata;
        REG_UNDERSPEED_LIMIT: underspeed_limit_rpm <= cfg_wdata;
        REG_UNDERSPEED_EN:    underspeed_enable    <= cfg_wdata[0];
        REG_RAMP_TIMEOUT:     timeout_ms <= 16'({10'd0, cfg_wdata[5:0]} * MS_PER_S);
        default: ;
      endcase
    end
  end

  // threshold derivation
  always_comb begin
    cfg.check_enable = check_enable;
    cfg.timeout_ms   = timeout_ms;
    cfg.speed_lo     = (crank_disconnect_rpm < LOWER_SPEED_FLOOR) ?
                       LOWER_SPEED_FLOOR : crank_disconnect_rpm;
    cfg.speed_hi     = (underspeed_enable && (underspeed_limit_rpm > UPPER_SPEED_DEFAULT)) ?
                       underspeed_limit_rpm : UPPER_SPEED_DEFAULT;
  end

endmodule

FILE: hw/rtl/esrv_ramp_fsm.sv
// ----------------------------------------------------------------------------
// esrv_ramp_fsm
// Four-phase ramp check machine with saturating elapsed counter.
// ----------------------------------------------------------------------------
module esrv_ramp_fsm
  import esrv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 check_enable,
  input  logic [SAMPLE_W-1:0]  sample,
  input  logic [SAMPLE_W-1:0]  lo,
  input  logic [SAMPLE_W-1:0]  hi,
  input  logic [ELAPSED_W-1:0] min_ms,
  input  logic [15:0]          timeout_ms,
  input  logic                 engine_off,
  output phase_t               phase_cur,
  output phase_t               phase_next,
  output logic                 ok_next
);

  phase_t               phase;
  logic [ELAPSED_W-1:0] elapsed;
  logic                 ok;
  logic [ELAPSED_W-1:0] elapsed_next;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic                 timed_out;

  assign phase_cur   = phase;
  assign elapsed_inc = (elapsed == ELAPSED_MAX) ? elapsed : elapsed + 1'b1;
  assign timed_out   = elapsed_inc >= {1'b0, timeout_ms};

  // next phase, counter and verdict
  always_comb begin
    phase_next   = phase;
    elapsed_next = elapsed;
    ok_next      = ok;
    if (step) begin
      case (phase)
        PH_IDLE: begin
          if (check_enable) begin
            if (sample > lo) begin
              elapsed_next = '0;
              phase_next   = PH_CHECK;
            end
          end else begin
            ok_next = 1'b1;
          end
        end
        PH_CHECK: begin
          elapsed_next = elapsed_inc;
          if (sample >= hi) begin
            ok_next    = elapsed_inc >= min_ms;
            phase_next = PH_DONE;
          end else if (timed_out && (sample >= lo)) begin
            ok_next    = 1'b1;
            phase_next = PH_DONE;
          end else if (timed_out) begin
            phase_next = PH_RESET;
          end
        end
        PH_DONE: begin
          if (engine_off) phase_next = PH_RESET;
        end
        default: begin
          elapsed_next = '0;
          ok_next      = 1'b1;
          phase_next   = PH_IDLE;
        end
      endcase
    end
  end

  // machine state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      elapsed <= '0;
      ok      <= 1'b1;
    end else begin
      phase   <= phase_next;
      elapsed <= elapsed_next;
      ok      <= ok_next;
    end
  end

endmodule

FILE: hw/rtl/engine_start_ramp_validator_top.sv
// ----------------------------------------------------------------------------
// engine_start_ramp_validator_top
// Path: input register, then result register; m_axis_tready can stall both.
// Throughput: one tick per cycle unless stalled; single-pass machine update.
// Reset: synchronous; machines idle, verdicts valid, detection off,
// ramp timeout 10 s, both pipeline stages empty.
// ----------------------------------------------------------------------------
module engine_start_ramp_validator_top
  import esrv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // tick input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // speed_rpm[15:0], voltage_raw[25:16], engine_off[26], config_mode[27], zero pad
  input  logic [31:0] s_axis_tdata,
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // valid_start[0], volt_ramp_valid[1], detection_enabled[2],
  // speed_phase[4:3], volt_phase[6:5], zero pad
  output logic [7:0]  m_axis_tdata
);

  cfg_t        cfg;
  logic        in_valid;
  logic [15:0] in_speed;
  logic [9:0]  in_volt;
  logic        in_engine_off;
  logic        in_config_mode;
  logic        advance;
  logic        step;
  logic        detect_on;
  logic        detect_next;
  phase_t      spd_cur, spd_next, vlt_cur, vlt_next;
  logic        spd_ok_next, vlt_ok_next;

  esrv_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // handshake: result stage frees up or is empty
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign step          = advance && !in_config_mode;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_speed       <= s_axis_tdata[15:0];
      in_volt        <= s_axis_tdata[25:16];
      in_engine_off  <= s_axis_tdata[26];
      in_config_mode <= s_axis_tdata[27];
    end
  end

  esrv_ramp_fsm u_speed (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .check_enable (cfg.check_enable),
    .sample       (in_speed),
    .lo           (cfg.speed_lo),
    .hi           (cfg.speed_hi),
    .min_ms       (MIN_SPEED_RAMP_MS),
    .timeout_ms   (cfg.timeout_ms),
    .engine_off   (in_engine_off),
    .phase_cur    (spd_cur),
    .phase_next   (spd_next),
    .ok_next      (spd_ok_next)
  );

  esrv_ramp_fsm u_volt (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .check_enable (cfg.check_enable),
    .sample       ({6'd0, in_volt}),
    .lo           (VOLT_LOW_LEVEL),
    .hi           (VOLT_HIGH_LEVEL),
    .min_ms       (MIN_VOLT_RAMP_MS),
    .timeout_ms   (cfg.timeout_ms),
    .engine_off   (in_engine_off),
    .phase_cur    (vlt_cur),
    .phase_next   (vlt_next),
    .ok_next      (vlt_ok_next)
  );

  // detection flag follows check_enable on stepped ticks while either machine sits idle
  assign detect_next = (step && ((spd_cur == PH_IDLE) || (vlt_cur == PH_IDLE))) ?
                       cfg.check_enable : detect_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_on <= 1'b0;
    end else begin
      detect_on <= detect_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {1'b0, vlt_next, spd_next, detect_next, vlt_ok_next, spd_ok_next};
    end
  end

endmodule
